### hdl/playfair_digraph_cipher_core_defines.svh
// Assertion macros used by the Playfair core port checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_CORE_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pfc_pkg.sv
// Types, codes and helper functions of the Playfair digraph cipher core.
// Has no dependencies; used by every other file of the core except pfc_ram and the defines header.
package pfc_pkg;

  localparam int SIDE        = 5;
  localparam int CELLS       = SIDE * SIDE;
  localparam int NUM_LETTERS = 26;
  localparam int CELL_W      = 5;
  localparam int LTR_W       = 5;
  localparam int RC_W        = 3;

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_KEYCHAR = 2'd1;
  localparam logic [1:0] ACT_FINISH  = 2'd2;
  localparam logic [1:0] ACT_ENCRYPT = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_KEY_SKIP  = 2'd1;
  localparam logic [1:0] ST_BAD_PAIR  = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  localparam logic [LTR_W-1:0] LTR_I = 5'd8;
  localparam logic [LTR_W-1:0] LTR_J = 5'd9;
  localparam logic [LTR_W-1:0] LTR_X = 5'd23;
  localparam logic [LTR_W-1:0] LTR_LAST = 5'd25;

  localparam logic [7:0] ASC_A       = 8'h41;
  localparam logic [7:0] ASC_Z       = 8'h5A;
  localparam logic [7:0] ASC_J       = 8'h4A;
  localparam logic [7:0] ASC_LOW_A   = 8'h61;
  localparam logic [7:0] ASC_LOW_Z   = 8'h7A;
  localparam logic [7:0] ASC_CASE    = 8'h20;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic       has_second;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cipher_first;
    logic [6:0] cipher_second;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic             ok;
    logic [LTR_W-1:0] idx;
  } letter_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic fill_step;
    logic crypt_done;
    logic load_out;
  } pfc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_fill;
    logic go_crypt;
    logic walk_last;
    logic out_free;
  } pfc_stat_t;

  // Upper-cases an ASCII byte and folds J into I.
  function automatic letter_t letter_of(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] diff;
    letter_t    r;
    u = c;
    if (c >= ASC_LOW_A && c <= ASC_LOW_Z) begin
      u = c - ASC_CASE;
    end
    diff  = u - ASC_A;
    r.ok  = (u >= ASC_A) && (u <= ASC_Z);
    r.idx = r.ok ? diff[LTR_W-1:0] : '0;
    if (r.idx == LTR_J) begin
      r.idx = LTR_I;
    end
    return r;
  endfunction

  function automatic logic [RC_W-1:0] pos_row(input logic [CELL_W-1:0] p);
    logic [RC_W-1:0] r;
    r = '0;
    for (int i = 1; i < SIDE; i++) begin
      if (p >= CELL_W'(i * SIDE)) begin
        r = RC_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [RC_W-1:0] pos_col(input logic [CELL_W-1:0] p,
                                              input logic [RC_W-1:0]   r);
    logic [CELL_W-1:0] t;
    t = p - CELL_W'(r) * CELL_W'(SIDE);
    return t[RC_W-1:0];
  endfunction

  function automatic logic [RC_W-1:0] inc_wrap(input logic [RC_W-1:0] k);
    return (k == RC_W'(SIDE - 1)) ? '0 : k + 1'b1;
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(input logic [RC_W-1:0] r,
                                               input logic [RC_W-1:0] k);
    return CELL_W'(r) * CELL_W'(SIDE) + CELL_W'(k);
  endfunction

endpackage

### hdl/pfc_ram.sv
// Generic RAM: one write port and two read ports with registered read data.
// No dependencies.
module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/pfc_ctrl.sv
// Controller of the Playfair core: sequences key fill, encryption and result hand-off.
// Depends on pfc_pkg for the command and status structs.
module pfc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pfc_pkg::pfc_stat_t stat,
  output pfc_pkg::pfc_cmd_t  cmd,
  output logic              in_stall
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.go_fill) begin
            state_next = S_FILL;
          end else if (stat.go_crypt) begin
            state_next = S_LOOK;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.walk_last) begin
          state_next = S_DONE;
        end
      end
      // Letter positions arrive from the position RAM; square reads go out.
      S_LOOK: state_next = S_READ;
      S_READ: begin
        cmd.crypt_done = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

### hdl/pfc_dpath.sv
// Datapath of the Playfair core: key state, square and position RAMs, result registers.
// Depends on pfc_pkg and pfc_ram.
module pfc_dpath (
  input  logic               clk,
  input  logic               rst,
  input  pfc_pkg::pfc_cmd_t  cmd,
  input  pfc_pkg::in_item_t  in_item,
  input  logic               out_stall,
  output pfc_pkg::pfc_stat_t stat,
  output logic               out_valid,
  output pfc_pkg::out_item_t out_item
);

  logic [pfc_pkg::NUM_LETTERS-1:0] used;
  logic [pfc_pkg::CELL_W-1:0]      fill;
  logic                            ready;
  logic [pfc_pkg::LTR_W-1:0]       walk;
  pfc_pkg::out_item_t              res;

  pfc_pkg::letter_t           fa;
  pfc_pkg::letter_t           fb;
  logic                       lb_ok;
  logic [pfc_pkg::LTR_W-1:0]  lb_idx;
  logic                       pair_ok;
  logic                       key_ok;
  logic                       walk_place;
  logic [1:0]                 acc_status;

  logic                       we;
  logic [pfc_pkg::LTR_W-1:0]  w_letter;
  logic [pfc_pkg::CELL_W-1:0] pa;
  logic [pfc_pkg::CELL_W-1:0] pb;
  logic [pfc_pkg::LTR_W-1:0]  sq_a;
  logic [pfc_pkg::LTR_W-1:0]  sq_b;
  logic [pfc_pkg::RC_W-1:0]   r1, k1, r2, k2;
  logic [pfc_pkg::CELL_W-1:0] o1, o2;

  // Input letters; a missing or repeated second letter becomes X.
  always_comb begin
    fa     = pfc_pkg::letter_of(in_item.first_char);
    fb     = pfc_pkg::letter_of(in_item.second_char);
    lb_ok  = in_item.has_second ? fb.ok : 1'b1;
    lb_idx = in_item.has_second ? fb.idx : pfc_pkg::LTR_X;
    if (lb_idx == fa.idx) begin
      lb_idx = pfc_pkg::LTR_X;
    end
    pair_ok = fa.ok && lb_ok;
  end

  assign key_ok = !ready && fa.ok && !used[fa.idx] &&
                  (fill < pfc_pkg::CELL_W'(pfc_pkg::CELLS));
  assign walk_place = (walk != pfc_pkg::LTR_J) && !used[walk] &&
                      (fill < pfc_pkg::CELL_W'(pfc_pkg::CELLS));

  assign stat.go_fill   = (in_item.action == pfc_pkg::ACT_FINISH) && !ready;
  assign stat.go_crypt  = (in_item.action == pfc_pkg::ACT_ENCRYPT) && ready && pair_ok;
  assign stat.walk_last = (walk == pfc_pkg::LTR_LAST);
  assign stat.out_free  = !out_valid || !out_stall;

  // Both RAMs are written together: square cell -> letter, letter -> cell.
  always_comb begin
    we       = 1'b0;
    w_letter = walk;
    if (cmd.accept && in_item.action == pfc_pkg::ACT_KEYCHAR && key_ok) begin
      we       = 1'b1;
      w_letter = fa.idx;
    end else if (cmd.fill_step && walk_place) begin
      we = 1'b1;
    end
  end

  pfc_ram #(
    .WIDTH (pfc_pkg::CELL_W),
    .DEPTH (pfc_pkg::NUM_LETTERS)
  ) u_pos_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (w_letter),
    .wdata   (fill),
    .raddr_a (fa.idx),
    .raddr_b (lb_idx),
    .rdata_a (pa),
    .rdata_b (pb)
  );

  always_comb begin
    r1 = pfc_pkg::pos_row(pa);
    r2 = pfc_pkg::pos_row(pb);
    k1 = pfc_pkg::pos_col(pa, r1);
    k2 = pfc_pkg::pos_col(pb, r2);
    if (r1 == r2) begin
      o1 = pfc_pkg::cell_of(r1, pfc_pkg::inc_wrap(k1));
      o2 = pfc_pkg::cell_of(r2, pfc_pkg::inc_wrap(k2));
    end else if (k1 == k2) begin
      o1 = pfc_pkg::cell_of(pfc_pkg::inc_wrap(r1), k1);
      o2 = pfc_pkg::cell_of(pfc_pkg::inc_wrap(r2), k2);
    end else begin
      o1 = pfc_pkg::cell_of(r1, k2);
      o2 = pfc_pkg::cell_of(r2, k1);
    end
  end

  pfc_ram #(
    .WIDTH (pfc_pkg::LTR_W),
    .DEPTH (pfc_pkg::CELLS)
  ) u_square_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (fill),
    .wdata   (w_letter),
    .raddr_a (o1),
    .raddr_b (o2),
    .rdata_a (sq_a),
    .rdata_b (sq_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      fill  <= '0;
      ready <= 1'b0;
      walk  <= '0;
    end else if (cmd.accept) begin
      unique case (in_item.action)
        pfc_pkg::ACT_START: begin
          used  <= '0;
          fill  <= '0;
          ready <= 1'b0;
        end
        pfc_pkg::ACT_KEYCHAR: begin
          if (key_ok) begin
            used[fa.idx] <= 1'b1;
            fill         <= fill + 1'b1;
          end
        end
        pfc_pkg::ACT_FINISH: walk <= '0;
        pfc_pkg::ACT_ENCRYPT: ;
        default: ;
      endcase
    end else if (cmd.fill_step) begin
      if (walk_place) begin
        used[walk] <= 1'b1;
        fill       <= fill + 1'b1;
      end
      walk <= walk + 1'b1;
      if (stat.walk_last) begin
        ready <= 1'b1;
      end
    end
  end

  // Status of a request as seen when it is accepted.
  always_comb begin
    acc_status = pfc_pkg::ST_OK;
    unique case (in_item.action)
      pfc_pkg::ACT_KEYCHAR: begin
        if (!key_ok) begin
          acc_status = pfc_pkg::ST_KEY_SKIP;
        end
      end
      pfc_pkg::ACT_ENCRYPT: begin
        if (!ready) begin
          acc_status = pfc_pkg::ST_NOT_READY;
        end else if (!pair_ok) begin
          acc_status = pfc_pkg::ST_BAD_PAIR;
        end
      end
      pfc_pkg::ACT_START, pfc_pkg::ACT_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res <= '{cipher_first: 7'd0, cipher_second: 7'd0, status: acc_status};
    end else if (cmd.crypt_done) begin
      res.cipher_first  <= 7'(pfc_pkg::ASC_A) + 7'(sq_a);
      res.cipher_second <= 7'(pfc_pkg::ASC_A) + 7'(sq_b);
      res.status        <= pfc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item <= res;
    end
  end

endmodule

### hdl/playfair_digraph_cipher_core.sv
// Top level of the Playfair digraph cipher core: controller plus datapath.
// Depends on pfc_pkg, pfc_ctrl, pfc_dpath and pfc_ram.
//
//   Channel | Handshake                    | Payload
//   --------+------------------------------+-------------------------------
//   in      | in_valid / in_stall          | in_item  (pfc_pkg::in_item_t)
//   out     | out_valid / out_stall        | out_item (pfc_pkg::out_item_t)
//
// Start key, key character, an already finished key and a flagged encrypt go straight
// from idle to the result hand-off. Encrypt of a good pair on a finished key first
// reads the position RAM, then the square RAM, both reads registered, before the hand-off.
// Finish key first runs the fill walk, which visits all 26 letters, one per cycle.
// Reset clears the key state; the square needs no clearing pass.
// A stalled result does not block the next request, but that request's result waits
// until the output is free before it is handed off.
module playfair_digraph_cipher_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output pfc_pkg::out_item_t out_item
);

  pfc_pkg::pfc_cmd_t  cmd;
  pfc_pkg::pfc_stat_t stat;

  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  pfc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### hdl/pfc_checker.sv
// Port-level checks of the Playfair core, attached to the top level by bind.
// Depends on pfc_pkg and playfair_digraph_cipher_core_defines.svh.
`include "playfair_digraph_cipher_core_defines.svh"

module pfc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input pfc_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input pfc_pkg::out_item_t out_item
);

  // A stalled result stays offered and unchanged.
  `PFC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

  // The core works on one request at a time.
  `PFC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request taken while busy")

  // Any error status comes with zero letters.
  `PFC_ASSERT_NOW(a_err_zero, out_valid && out_item.status != pfc_pkg::ST_OK, out_item.cipher_first == 7'd0 && out_item.cipher_second == 7'd0, "error result carries letters")

  // The first ciphertext letter, when present, is upper case and never J.
  `PFC_ASSERT_NOW(a_letter_range, out_valid && out_item.cipher_first != 7'd0, out_item.cipher_first >= 7'(pfc_pkg::ASC_A) && out_item.cipher_first <= 7'(pfc_pkg::ASC_Z) && out_item.cipher_first != 7'(pfc_pkg::ASC_J), "ciphertext letter out of range")

endmodule

bind playfair_digraph_cipher_core pfc_checker u_pfc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

### verif/playfair_cipher_checker.sv
// Checker for the Playfair digraph cipher core: watches the request and result channels,
// predicts every ciphertext result and compares it with what the core returns.
// Depends on pfc_pkg for the payload types, action codes and status codes.
module playfair_cipher_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  pfc_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  pfc_pkg::out_item_t out_item,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfc_pkg::*;

  // Shadow copy of the key state.
  logic [LTR_W-1:0]       square [CELLS];
  logic [NUM_LETTERS-1:0] used;
  int                     fill_pos;
  bit                     ready;

  out_item_t expected_ciphers [$];
  out_item_t want;

  // Letter index of an ASCII byte, J folded to I, or -1 for a non-letter.
  function automatic int fold_letter(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (u >= ASC_LOW_A && u <= ASC_LOW_Z) begin
      u = u - ASC_CASE;
    end
    if (u < ASC_A || u > ASC_Z) begin
      return -1;
    end
    if (int'(u - ASC_A) == int'(LTR_J)) begin
      return int'(LTR_I);
    end
    return int'(u - ASC_A);
  endfunction

  function automatic void place_letter(input int letter);
    if (fill_pos < CELLS) begin
      square[fill_pos] = LTR_W'(letter);
      fill_pos++;
    end
    used[letter] = 1'b1;
  endfunction

  function automatic int locate_letter(input int letter);
    for (int i = 0; i < CELLS; i++) begin
      if (int'(square[i]) == letter) begin
        return i;
      end
    end
    return 0;
  endfunction

  function automatic out_item_t encipher(input in_item_t req);
    out_item_t res;
    int        a, b, pa, pb, r1, k1, r2, k2, o1, o2;
    res = '0;
    case (req.action)
      ACT_START: begin
        // The square itself is left alone: it is fully rewritten before any read.
        used     = '0;
        fill_pos = 0;
        ready    = 1'b0;
      end
      ACT_KEYCHAR: begin
        a = fold_letter(req.first_char);
        if (ready || a < 0 || fill_pos >= CELLS) begin
          res.status = ST_KEY_SKIP;
        end else if (used[a]) begin
          res.status = ST_KEY_SKIP;
        end else begin
          place_letter(a);
        end
      end
      ACT_FINISH: begin
        if (!ready) begin
          for (int l = 0; l < NUM_LETTERS; l++) begin
            if (l != int'(LTR_J) && !used[l]) begin
              place_letter(l);
            end
          end
          ready = 1'b1;
        end
      end
      ACT_ENCRYPT: begin
        a = fold_letter(req.first_char);
        b = req.has_second ? fold_letter(req.second_char) : int'(LTR_X);
        if (!ready) begin
          res.status = ST_NOT_READY;
        end else if (a < 0 || b < 0) begin
          res.status = ST_BAD_PAIR;
        end else begin
          if (a == b) begin
            b = int'(LTR_X);
          end
          pa = locate_letter(a);
          pb = locate_letter(b);
          r1 = pa / SIDE;
          k1 = pa % SIDE;
          r2 = pb / SIDE;
          k2 = pb % SIDE;
          if (r1 == r2) begin
            o1 = r1 * SIDE + (k1 + 1) % SIDE;
            o2 = r2 * SIDE + (k2 + 1) % SIDE;
          end else if (k1 == k2) begin
            o1 = ((r1 + 1) % SIDE) * SIDE + k1;
            o2 = ((r2 + 1) % SIDE) * SIDE + k2;
          end else begin
            o1 = r1 * SIDE + k2;
            o2 = r2 * SIDE + k1;
          end
          res.cipher_first  = 7'(int'(ASC_A) + int'(square[o1]));
          res.cipher_second = 7'(int'(ASC_A) + int'(square[o2]));
        end
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Sampled at the rising edge; the stimulus only moves on falling edges.
  always @(posedge clk) begin
    if (rst) begin
      used       = '0;
      fill_pos   = 0;
      ready      = 1'b0;
      mismatches = 0;
      expected_ciphers.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_ciphers.size() == 0) begin
          $error("result returned with no request outstanding: %p", out_item);
          mismatches++;
        end else begin
          want = expected_ciphers.pop_front();
          compare_field("cipher_first", want.cipher_first, out_item.cipher_first);
          compare_field("cipher_second", want.cipher_second, out_item.cipher_second);
          compare_field("status", want.status, out_item.status);
        end
      end
      if (in_valid && !in_stall) begin
        expected_ciphers.push_back(encipher(in_item));
      end
    end
    outstanding = expected_ciphers.size();
  end

endmodule

### verif/playfair_digraph_cipher_core_tb.sv
// Testbench top for the Playfair digraph cipher core: clock, reset, request stimulus
// and result back-pressure. Depends on pfc_pkg, the core and playfair_cipher_checker.
module playfair_digraph_cipher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfc_pkg::*;

  localparam int REQUEST_TARGET = 1100;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 40;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int   mismatches;
  int   outstanding;
  int   sent;
  logic calm;
  logic hold_req;

  playfair_digraph_cipher_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  playfair_cipher_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Entered and left on a falling edge.
  task automatic send(input logic [1:0] action, input logic [7:0] c1,
                      input logic [7:0] c2, input logic has2);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{action: action, first_char: c1, second_char: c2, has_second: has2};
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] ascii_of(input int idx, input bit lower);
    return (lower ? ASC_LOW_A : ASC_A) + 8'(idx);
  endfunction

  task automatic send_junk_key(input logic [1:0] action);
    send(action, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_pair();
    int         a, b;
    logic [7:0] c1, c2;
    logic       has2;
    a = $urandom_range(0, 25);
    b = $urandom_range(0, 25);
    if ($urandom_range(0, 99) < 8) begin
      b = a;
    end
    c1 = ascii_of(a, 1'($urandom));
    c2 = ascii_of(b, 1'($urandom));
    if ($urandom_range(0, 99) < 5) begin
      c1 = 8'($urandom);
    end
    if ($urandom_range(0, 99) < 5) begin
      c2 = 8'($urandom);
    end
    has2 = ($urandom_range(0, 99) < 90);
    if (!has2) begin
      c2 = 8'($urandom);
    end
    send(ACT_ENCRYPT, c1, c2, has2);
  endtask

  // One well-formed session: start, key characters, finish, then pairs.
  task automatic run_session();
    int         perm [NUM_LETTERS];
    int         n, j, t;
    logic [7:0] c;
    send_junk_key(ACT_START);
    if ($urandom_range(0, 7) == 0) begin
      // Whole alphabet in random order: fills the square before finish.
      for (int i = 0; i < NUM_LETTERS; i++) begin
        perm[i] = i;
      end
      for (int i = NUM_LETTERS - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = perm[i];
        perm[i] = perm[j];
        perm[j] = t;
      end
      for (int i = 0; i < NUM_LETTERS; i++) begin
        send(ACT_KEYCHAR, ascii_of(perm[i], 1'($urandom)), 8'($urandom), 1'($urandom));
      end
    end else begin
      n = $urandom_range(0, 14);
      for (int i = 0; i < n; i++) begin
        c = ($urandom_range(0, 99) < 75) ? ascii_of($urandom_range(0, 25), 1'($urandom))
                                         : 8'($urandom);
        send(ACT_KEYCHAR, c, 8'($urandom), 1'($urandom));
      end
    end
    send_junk_key(ACT_FINISH);
    if ($urandom_range(0, 5) == 0) begin
      send_junk_key(ACT_FINISH);
    end
    if ($urandom_range(0, 5) == 0) begin
      send(ACT_KEYCHAR, ascii_of($urandom_range(0, 25), 1'($urandom)), 8'($urandom), 1'b0);
    end
    n = $urandom_range(4, 24);
    for (int i = 0; i < n; i++) begin
      send_pair();
    end
  endtask

  initial begin
    forever begin
      #4_000_000;
      $display("FAILURE");
      $finish;
    end
  end

  // Result side back-pressure, with one long hold-off while requests keep coming.
  initial begin
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 11);
      end
    end
  end

  initial begin
    bit paused;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_item  = '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    sent     = 0;
    paused   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening: corner cases of the key build and of the pair rules.
    send(ACT_ENCRYPT, "A", "B", 1'b1);
    send(ACT_START, 8'hFF, 8'h00, 1'b1);
    send(ACT_KEYCHAR, "p", 8'h00, 1'b0);
    send(ACT_KEYCHAR, "J", 8'hFF, 1'b1);
    send(ACT_KEYCHAR, "i", 8'h00, 1'b0);
    send(ACT_KEYCHAR, "1", 8'h00, 1'b0);
    send(ACT_KEYCHAR, 8'hFF, 8'h00, 1'b0);
    send(ACT_KEYCHAR, "Z", 8'h00, 1'b0);
    send(ACT_KEYCHAR, "a", 8'h00, 1'b0);
    send(ACT_FINISH, 8'h00, 8'h00, 1'b0);
    send(ACT_FINISH, 8'hFF, 8'hFF, 1'b1);
    send(ACT_KEYCHAR, "B", 8'h00, 1'b0);
    send(ACT_ENCRYPT, "H", "E", 1'b1);
    send(ACT_ENCRYPT, "L", "L", 1'b1);
    send(ACT_ENCRYPT, "X", "x", 1'b1);
    send(ACT_ENCRYPT, "q", 8'hFF, 1'b0);
    send(ACT_ENCRYPT, "A", "{", 1'b1);
    send(ACT_ENCRYPT, 8'h00, "B", 1'b1);
    send(ACT_ENCRYPT, "j", "i", 1'b1);
    send(ACT_ENCRYPT, "Z", "a", 1'b1);
    send(ACT_ENCRYPT, "z", "@", 1'b0);
    send(ACT_START, 8'h00, 8'h00, 1'b0);
    send(ACT_FINISH, 8'h00, 8'h00, 1'b0);
    send(ACT_ENCRYPT, "A", "Y", 1'b1);

    while (sent < REQUEST_TARGET) begin
      calm <= (sent >= 700 && sent < 950);
      if (sent >= 300) begin
        hold_req <= 1'b1;
      end
      if (sent >= 600 && !paused) begin
        // Let the core drain completely before carrying on.
        paused = 1'b1;
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        @(negedge clk);
      end
      if ($urandom_range(0, 99) < 85) begin
        run_session();
      end else begin
        repeat ($urandom_range(1, 3)) send_junk_key(2'($urandom));
      end
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/pfc_pkg.sv
hdl/pfc_ram.sv
hdl/pfc_ctrl.sv
hdl/pfc_dpath.sv
hdl/playfair_digraph_cipher_core.sv
hdl/pfc_checker.sv
verif/playfair_cipher_checker.sv
verif/playfair_digraph_cipher_core_tb.sv
